// ===== rtl/core/egvd_pkg.sv =====
`timescale 1ns / 1ps
package egvd_pkg;

    localparam int FRAME_SAMPLES = 320;
    localparam int CNT_W   = 10;
    localparam int N_W     = 11;
    localparam int SUM_W   = 39;
    localparam int EN_W    = 46;
    localparam int RATIO_W = 40;
    localparam int PRED_W  = 48;
    localparam int DVD_W   = 64;
    localparam int DVS_W   = 48;
    localparam int MUL_W   = 48;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [EN_W-1:0]    EN_MAX    = {EN_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
    localparam logic [PRED_W-1:0]  PRED_MAX  = {PRED_W{1'b1}};
    localparam logic [PRED_W-1:0]  PRED_ONE  = 48'd65536;

    localparam logic [16:0] W_ONE       = 17'd65536;
    localparam logic [16:0] CAL_WEIGHT  = 17'd6554;
    localparam logic [16:0] FALL_WEIGHT = 17'd13107;
    localparam logic [16:0] RISE_WEIGHT = 17'd328;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_TAIL      = 3'd1,
        REG_CAL       = 3'd2,
        REG_HOLD      = 3'd3,
        REG_DECAY     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [29:0] thr;
        logic [7:0]  tail;
        logic [5:0]  calf;
        logic [3:0]  hold;
        logic [15:0] decay;
    } cfg_t;

    typedef struct packed {
        logic             restart;
        logic             vad;
        logic             aligned;
        logic [N_W-1:0]   n;
        logic [SUM_W-1:0] s_out;
        logic [SUM_W-1:0] s_ml;
        logic [SUM_W-1:0] s_mr;
        logic [SUM_W-1:0] s_ref;
    } job_t;

endpackage

// ===== rtl/core/egvd_front.sv =====
`timescale 1ns / 1ps
module egvd_front import egvd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    input  logic [2:0]  s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    function automatic logic [SUM_W-1:0] acc_sq(input logic [SUM_W-1:0] sum,
                                                 input logic signed [15:0] x);
        logic signed [31:0] p;
        logic [SUM_W:0]     t;
        p = x * x;
        t = {1'b0, sum} + (SUM_W+1)'($unsigned(p));
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

    logic [SUM_W-1:0] s_out_reg, s_ml_reg, s_mr_reg, s_ref_reg;
    logic [SUM_W-1:0] s_out_next, s_ml_next, s_mr_next, s_ref_next;
    logic [CNT_W-1:0] count_reg;
    logic [N_W-1:0]   n;
    logic             accept, frame_end, restart;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign restart  = s_tuser[2];

    always_comb begin
        s_out_next = acc_sq(s_out_reg, s_tdata[15:0]);
        s_ml_next  = acc_sq(s_ml_reg,  s_tdata[31:16]);
        s_mr_next  = acc_sq(s_mr_reg,  s_tdata[47:32]);
        s_ref_next = acc_sq(s_ref_reg, s_tdata[63:48]);
        n          = {1'b0, count_reg} + N_W'(1);
        frame_end  = s_tlast || (n >= N_W'(FRAME_SAMPLES));
        q_push     = accept && (restart || frame_end);
        q_job.restart = restart;
        q_job.vad     = s_tuser[0];
        q_job.aligned = s_tuser[1];
        q_job.n       = n;
        q_job.s_out   = s_out_next;
        q_job.s_ml    = s_ml_next;
        q_job.s_mr    = s_mr_next;
        q_job.s_ref   = s_ref_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_out_reg <= '0;
            s_ml_reg  <= '0;
            s_mr_reg  <= '0;
            s_ref_reg <= '0;
            count_reg <= '0;
        end else if (accept) begin
            if (restart || frame_end) begin
                s_out_reg <= '0;
                s_ml_reg  <= '0;
                s_mr_reg  <= '0;
                s_ref_reg <= '0;
                count_reg <= '0;
            end else begin
                s_out_reg <= s_out_next;
                s_ml_reg  <= s_ml_next;
                s_mr_reg  <= s_mr_next;
                s_ref_reg <= s_ref_next;
                count_reg <= n[CNT_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/egvd_queue.sv =====
`timescale 1ns / 1ps
module egvd_queue import egvd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t job_in,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t job_out
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   fill_reg;

    assign full    = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign valid   = (fill_reg != '0);
    assign job_out = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= job_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (PTR_W+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/core/egvd_div.sv =====
`timescale 1ns / 1ps
module egvd_div import egvd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int C_W = $clog2(DVD_W);

    logic             busy_reg, done_reg;
    logic [C_W-1:0]   cnt_reg;
    logic [DVS_W-1:0] rem_reg, dvs_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W:0]   trial;
    logic             qbit;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
        rem_next = qbit ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            dvd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                dvd_reg  <= dividend;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
                cnt_reg <= cnt_reg + C_W'(1);
                if (cnt_reg == C_W'(DVD_W-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/egvd_mul.sv =====
`timescale 1ns / 1ps
module egvd_mul import egvd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_W-1:0]   a,
    input  logic [MUL_W-1:0]   b,
    output logic               done,
    output logic               busy,
    output logic [2*MUL_W-1:0] prod
);

    localparam int C_W = $clog2(MUL_W);

    logic               busy_reg, done_reg;
    logic [C_W-1:0]     cnt_reg;
    logic [2*MUL_W-1:0] acc_reg, ash_reg;
    logic [MUL_W-1:0]   bsh_reg;

    assign done = done_reg;
    assign busy = busy_reg;
    assign prod = acc_reg;

    // Shift and add, one multiplier bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            ash_reg  <= '0;
            bsh_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                ash_reg  <= {{MUL_W{1'b0}}, a};
                bsh_reg  <= b;
            end else if (busy_reg) begin
                if (bsh_reg[0]) begin
                    acc_reg <= acc_reg + ash_reg;
                end
                ash_reg <= {ash_reg[2*MUL_W-2:0], 1'b0};
                bsh_reg <= {1'b0, bsh_reg[MUL_W-1:1]};
                cnt_reg <= cnt_reg + C_W'(1);
                if (cnt_reg == C_W'(MUL_W-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/egvd_back.sv =====
`timescale 1ns / 1ps
module egvd_back import egvd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic q_valid,
    input  job_t q_job,
    output logic q_pop,
    output logic m_valid,
    input  logic m_ready,
    output logic m_echo,
    output logic m_near
);

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_MEAN_GO = 16'h0002,
        ST_MEAN_WT = 16'h0004,
        ST_ENV_GO  = 16'h0008,
        ST_ENV_WT  = 16'h0010,
        ST_BRANCH  = 16'h0020,
        ST_CDIV_GO = 16'h0040,
        ST_CDIV_WT = 16'h0080,
        ST_CMUL_GO = 16'h0100,
        ST_CMUL_WT = 16'h0200,
        ST_VMUL_GO = 16'h0400,
        ST_VMUL_WT = 16'h0800,
        ST_VOTE    = 16'h1000,
        ST_NMUL_GO = 16'h2000,
        ST_NMUL_WT = 16'h4000,
        ST_FINISH  = 16'h8000
    } state_t;

    state_t             state_reg;
    job_t               job_reg;
    logic [1:0]         k_reg;
    logic               sel_reg;
    logic [EN_W-1:0]    e_out_reg, e_ml_reg, e_mr_reg, e_ref_reg;
    logic [EN_W-1:0]    prev_mic_reg, prev_ref_reg, env_reg, nf_reg;
    logic               prev_al_reg, prev_valid_reg;
    logic [7:0]         tail_reg;
    logic [5:0]         cal_reg;
    logic [3:0]         hold_reg;
    logic [2:0]         vote_reg;
    logic [RATIO_W-1:0] mratio_reg, oratio_reg, ratio_reg;
    logic [PRED_W-1:0]  pm_reg, po_reg;
    logic               active_reg, admit_reg, up_reg;
    logic               out_valid_reg, out_echo_reg, out_near_reg;

    logic               div_start, div_done;
    logic [DVD_W-1:0]   div_dvd, div_q;
    logic [DVS_W-1:0]   div_dvs;
    logic               mul_start, mul_done, mul_busy;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;

    logic               context_w, finish_go;
    logic [SUM_W-1:0]   mean_sum;
    logic [EN_W-1:0]    mean_sat, decayed, cal_num;
    logic [RATIO_W-1:0] cal_x, cal_diff, cal_step, cal_new;
    logic               cal_up;
    logic [16:0]        cal_w;
    logic [PRED_W-1:0]  prod_sat;
    logic [EN_W:0]      nf_hi, nf_b, nf_diff, nf_step;
    logic [EN_W-1:0]    nf_lo;
    logic               nf_up;
    logic [EN_W+1:0]    nf_new;
    logic [PRED_W+1:0]  pm3, po3;
    logic [PRED_W+2:0]  po6;
    logic               evidence, maj;
    logic [2:0]         hist_n;
    logic [3:0]         hold_n;

    egvd_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dvd), .divisor(div_dvs), .done(div_done), .quotient(div_q)
    );

    egvd_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .busy(mul_busy), .prod(mul_p)
    );

    assign context_w = active_reg || (tail_reg != '0);
    assign finish_go = !out_valid_reg || m_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign m_valid   = out_valid_reg;
    assign m_echo    = out_echo_reg;
    assign m_near    = out_near_reg;

    always_comb begin
        unique case (k_reg)
            2'd0:    mean_sum = job_reg.s_out;
            2'd1:    mean_sum = job_reg.s_ml;
            2'd2:    mean_sum = job_reg.s_mr;
            default: mean_sum = job_reg.s_ref;
        endcase
        mean_sat = (div_q[DVD_W-1:EN_W] != '0) ? EN_MAX : div_q[EN_W-1:0];
        decayed  = mul_p[EN_W+15:16];
        prod_sat = (mul_p[2*MUL_W-1:PRED_W+16] != '0) ? PRED_MAX : mul_p[PRED_W+15:16];

        cal_num  = sel_reg ? e_out_reg : prev_mic_reg;
        cal_x    = sel_reg ? oratio_reg : mratio_reg;
        cal_up   = (ratio_reg >= cal_x);
        cal_diff = cal_up ? ratio_reg - cal_x : cal_x - ratio_reg;
        cal_w    = (cal_reg == '0) ? W_ONE : CAL_WEIGHT;
        cal_step = mul_p[RATIO_W+15:16];
        cal_new  = up_reg ? cal_x + cal_step : cal_x - cal_step;

        nf_lo = {1'b0, nf_reg[EN_W-1:1]};
        nf_hi = {nf_reg, 1'b0};
        if (e_out_reg < nf_lo) begin
            nf_b = {1'b0, nf_lo};
        end else if ({1'b0, e_out_reg} > nf_hi) begin
            nf_b = nf_hi;
        end else begin
            nf_b = {1'b0, e_out_reg};
        end
        nf_up   = (nf_b >= {1'b0, nf_reg});
        nf_diff = nf_up ? nf_b - {1'b0, nf_reg} : {1'b0, nf_reg} - nf_b;
        nf_step = mul_p[EN_W+16:16];
        nf_new  = up_reg ? {1'b0, nf_reg, 1'b0} - {1'b0, nf_reg, 1'b0}
                           + {2'b0, nf_reg} + {1'b0, nf_step}
                         : {2'b0, nf_reg} - {1'b0, nf_step};

        pm3 = {2'b0, pm_reg} + {1'b0, pm_reg, 1'b0};
        po3 = {2'b0, po_reg} + {1'b0, po_reg, 1'b0};
        po6 = {po3, 1'b0};
        evidence = job_reg.vad &&
            ((({4'b0, prev_mic_reg} > pm3) && ({4'b0, e_out_reg} > po3)) ||
             (({3'b0, prev_mic_reg, 1'b0} > pm3) && ({5'b0, e_out_reg} > po6)));
        hist_n = {vote_reg[1:0], evidence};
        maj    = (hist_n[0] && hist_n[1]) || (hist_n[0] && hist_n[2]) ||
                 (hist_n[1] && hist_n[2]);
        hold_n = maj ? cfg.hold : hold_reg;

        div_start = 1'b0;
        div_dvd   = {{(DVD_W-SUM_W-16){1'b0}}, mean_sum, 16'b0};
        div_dvs   = DVS_W'(job_reg.n);
        mul_start = 1'b0;
        mul_a     = MUL_W'(env_reg);
        mul_b     = MUL_W'(cfg.decay);
        unique case (state_reg)
            ST_MEAN_GO: div_start = 1'b1;
            ST_ENV_GO:  mul_start = 1'b1;
            ST_CDIV_GO: begin
                div_start = (prev_ref_reg != '0);
                div_dvd   = {{(DVD_W-EN_W-16){1'b0}}, cal_num, 16'b0};
                div_dvs   = DVS_W'(prev_ref_reg);
            end
            ST_CMUL_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(cal_diff);
                mul_b     = MUL_W'(cal_w);
            end
            ST_VMUL_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(sel_reg ? oratio_reg : mratio_reg);
                mul_b     = MUL_W'(env_reg);
            end
            ST_NMUL_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_W'(nf_diff);
                mul_b     = MUL_W'(nf_up ? RISE_WEIGHT : FALL_WEIGHT);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            sel_reg        <= 1'b0;
            prev_mic_reg   <= '0;
            prev_ref_reg   <= '0;
            prev_al_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            env_reg        <= '0;
            tail_reg       <= '0;
            cal_reg        <= '0;
            hold_reg       <= '0;
            vote_reg       <= '0;
            mratio_reg     <= '0;
            oratio_reg     <= '0;
            nf_reg         <= EN_W'(65536);
            active_reg     <= 1'b0;
            admit_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_echo_reg   <= 1'b0;
            out_near_reg   <= 1'b0;
        end else begin
            // In the finish state the output register is reloaded instead.
            if (out_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        job_reg <= q_job;
                        k_reg   <= '0;
                        if (q_job.restart) begin
                            // A restart word wipes all frame history.
                            prev_mic_reg   <= '0;
                            prev_ref_reg   <= '0;
                            prev_al_reg    <= 1'b0;
                            prev_valid_reg <= 1'b0;
                            env_reg        <= '0;
                            tail_reg       <= '0;
                            cal_reg        <= '0;
                            hold_reg       <= '0;
                            vote_reg       <= '0;
                            mratio_reg     <= '0;
                            oratio_reg     <= '0;
                            nf_reg         <= EN_W'(65536);
                            active_reg     <= 1'b0;
                        end else begin
                            state_reg <= ST_MEAN_GO;
                        end
                    end
                end
                ST_MEAN_GO: state_reg <= ST_MEAN_WT;
                ST_MEAN_WT: begin
                    if (div_done) begin
                        unique case (k_reg)
                            2'd0:    e_out_reg <= mean_sat;
                            2'd1:    e_ml_reg  <= mean_sat;
                            2'd2:    e_mr_reg  <= mean_sat;
                            default: e_ref_reg <= mean_sat;
                        endcase
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd3) ? ST_ENV_GO : ST_MEAN_GO;
                    end
                end
                ST_ENV_GO: begin
                    active_reg <= prev_al_reg && (prev_ref_reg >= {cfg.thr, 16'b0});
                    state_reg  <= ST_ENV_WT;
                end
                ST_ENV_WT: begin
                    if (mul_done) begin
                        if (active_reg) begin
                            tail_reg <= cfg.tail;
                            env_reg  <= (prev_ref_reg > decayed) ? prev_ref_reg : decayed;
                        end else if (tail_reg != '0) begin
                            tail_reg <= tail_reg - 8'd1;
                            env_reg  <= decayed;
                        end
                        state_reg <= ST_BRANCH;
                    end
                end
                ST_BRANCH: begin
                    admit_reg <= !context_w;
                    sel_reg   <= 1'b0;
                    if (prev_valid_reg && context_w) begin
                        if (active_reg && (cal_reg < cfg.calf)) begin
                            state_reg <= ST_CDIV_GO;
                        end else if (cal_reg >= cfg.calf) begin
                            state_reg <= ST_VMUL_GO;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end else if (!job_reg.vad) begin
                        state_reg <= ST_NMUL_GO;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_CDIV_GO: begin
                    if (prev_ref_reg == '0) begin
                        ratio_reg <= RATIO_MAX;
                        state_reg <= ST_CMUL_GO;
                    end else begin
                        state_reg <= ST_CDIV_WT;
                    end
                end
                ST_CDIV_WT: begin
                    if (div_done) begin
                        ratio_reg <= (div_q[DVD_W-1:RATIO_W] != '0) ? RATIO_MAX
                                                                   : div_q[RATIO_W-1:0];
                        state_reg <= ST_CMUL_GO;
                    end
                end
                ST_CMUL_GO: begin
                    up_reg    <= cal_up;
                    state_reg <= ST_CMUL_WT;
                end
                ST_CMUL_WT: begin
                    if (mul_done) begin
                        if (sel_reg) begin
                            oratio_reg <= cal_new;
                            cal_reg    <= cal_reg + 6'd1;
                            state_reg  <= ST_FINISH;
                        end else begin
                            mratio_reg <= cal_new;
                            sel_reg    <= 1'b1;
                            state_reg  <= ST_CDIV_GO;
                        end
                    end
                end
                ST_VMUL_GO: state_reg <= ST_VMUL_WT;
                ST_VMUL_WT: begin
                    if (mul_done) begin
                        if (sel_reg) begin
                            po_reg    <= (prod_sat < PRED_W'(nf_reg)) ? PRED_W'(nf_reg)
                                                                      : prod_sat;
                            state_reg <= ST_VOTE;
                        end else begin
                            pm_reg    <= (prod_sat < PRED_ONE) ? PRED_ONE : prod_sat;
                            sel_reg   <= 1'b1;
                            state_reg <= ST_VMUL_GO;
                        end
                    end
                end
                ST_VOTE: begin
                    vote_reg  <= hist_n;
                    admit_reg <= (hold_n != '0);
                    hold_reg  <= (hold_n != '0) ? hold_n - 4'd1 : 4'd0;
                    state_reg <= ST_FINISH;
                end
                ST_NMUL_GO: begin
                    up_reg    <= nf_up;
                    state_reg <= ST_NMUL_WT;
                end
                ST_NMUL_WT: begin
                    if (mul_done) begin
                        nf_reg    <= (nf_new[EN_W+1:EN_W] != '0) ? EN_MAX : nf_new[EN_W-1:0];
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (finish_go) begin
                        out_valid_reg  <= 1'b1;
                        out_echo_reg   <= context_w;
                        out_near_reg   <= job_reg.vad && admit_reg;
                        prev_mic_reg   <= (e_ml_reg > e_mr_reg) ? e_ml_reg : e_mr_reg;
                        prev_ref_reg   <= e_ref_reg;
                        prev_al_reg    <= job_reg.aligned;
                        prev_valid_reg <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("job taken from queue outside idle");

    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && finish_go |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("frame result not loaded into output register");

    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier restarted while busy");

    a_near_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) && out_near_reg && !out_echo_reg |-> $past(job_reg.vad))
        else $error("near voice flagged without voice activity");

endmodule

// ===== rtl/core/echo_gated_voice_detector_top.sv =====
`timescale 1ns / 1ps
// Each sample word is taken on its handshake; a frame's result is computed after its last
// word by the frame engine, which runs the serial divider and multiplier.
// Throughput: one word per cycle while the two-entry frame queue has room; the frame
// engine then handles one frame at a time, so frames that end faster than it finishes them stall input.
// Reset: aresetn is synchronous, active low; it clears all history and restores the
// register defaults.
module echo_gated_voice_detector_top import egvd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // out_sample, mic_left_sample, mic_right_sample, ref_sample
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    // vad_now, ref_aligned, restart
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // echo context flag, near-end voice flag, zero padding
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_data
);

    cfg_t cfg_reg;
    job_t q_in, q_out;
    logic q_push, q_full, q_pop, q_valid, echo, near;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thr   <= 30'd64;
            cfg_reg.tail  <= 8'd25;
            cfg_reg.calf  <= 6'd30;
            cfg_reg.hold  <= 4'd8;
            cfg_reg.decay <= 16'd47186;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_THRESHOLD: cfg_reg.thr   <= cfg_data;
                REG_TAIL:      cfg_reg.tail  <= cfg_data[7:0];
                REG_CAL:       cfg_reg.calf  <= cfg_data[5:0];
                REG_HOLD:      cfg_reg.hold  <= cfg_data[3:0];
                REG_DECAY:     cfg_reg.decay <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    egvd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tuser(s_tuser),
        .q_full(q_full), .q_push(q_push), .q_job(q_in)
    );

    egvd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .job_in(q_in), .full(q_full),
        .pop(q_pop), .valid(q_valid), .job_out(q_out)
    );

    egvd_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .q_valid(q_valid), .q_job(q_out),
        .q_pop(q_pop), .m_valid(m_tvalid), .m_ready(m_tready), .m_echo(echo), .m_near(near)
    );

    assign m_tdata = {6'b0, near, echo};

endmodule
